/* rtl/core/pcmfade_pkg.sv */
// ----------------------------------------------------------------------------
// pcmfade_pkg
// Shared types, codes and sizes for the linear PCM fade ramp.
// ----------------------------------------------------------------------------
package pcmfade_pkg;

   localparam int FADE_STEPS   = 16;
   localparam int MAX_FRAMES   = 4096;
   localparam int MAX_CHANNELS = 8;

   localparam int SAMPLE_W  = 16;
   localparam int CFG_FRM_W = 13;
   localparam int CFG_CH_W  = 4;
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 1;

   localparam int FRM_W  = $clog2(MAX_FRAMES + 1);
   localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CH_W   = $clog2(MAX_CHANNELS);
   localparam int STEP_W = $clog2(FADE_STEPS + 1);
   localparam int NUM_W  = $clog2(FADE_STEPS * MAX_FRAMES + 1);
   localparam int PROD_W = SAMPLE_W + NUM_W;

   localparam int MUL_CYCLES = NUM_W;
   localparam int DIV_CYCLES = SAMPLE_W;
   localparam int CNT_W      = $clog2((MUL_CYCLES > DIV_CYCLES) ? MUL_CYCLES : DIV_CYCLES);

   // item kinds
   localparam logic [1:0] KIND_SAMPLE   = 2'd0;
   localparam logic [1:0] KIND_FADE_OUT = 2'd1;
   localparam logic [1:0] KIND_FADE_IN  = 2'd2;
   localparam logic [1:0] KIND_CANCEL   = 2'd3;

   // fade modes
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_OUT  = 2'd1;
   localparam logic [1:0] MODE_IN   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAMES   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS = 1'b1;

   typedef struct packed {
      logic [1:0]                 kind;
      logic signed [SAMPLE_W-1:0] sample_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       buffer_last;
      logic [1:0]                 fade_state;
   } rsp_type;

   // one scaling job: |s| * num / den, sign applied at the end
   typedef struct packed {
      logic [SAMPLE_W-1:0] mag;
      logic                neg;
      logic [NUM_W-1:0]    num;
      logic [NUM_W-1:0]    den;
   } job_type;

   typedef struct packed {
      logic idle;
      logic done;
   } stat_type;

endpackage

/* rtl/core/pcmfade_scale.sv */
// ----------------------------------------------------------------------------
// pcmfade_scale
// Bit-serial scaler: shift-add multiply of the sample magnitude by the gain
// numerator, then restoring division by the denominator, one bit per cycle.
// ----------------------------------------------------------------------------
module pcmfade_scale (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  pcmfade_pkg::job_type                   job,
   input  logic                                   take,
   output pcmfade_pkg::stat_type                  stat,
   output logic signed [pcmfade_pkg::SAMPLE_W-1:0] result
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [pcmfade_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [pcmfade_pkg::PROD_W-1:0]   acc_ff, acc_in;
   logic [pcmfade_pkg::PROD_W-1:0]   mcand_ff, mcand_in;
   logic [pcmfade_pkg::NUM_W-1:0]    mplier_ff, mplier_in;
   logic [pcmfade_pkg::NUM_W-1:0]    den_ff, den_in;
   logic [pcmfade_pkg::NUM_W-1:0]    rem_ff, rem_in;
   logic [pcmfade_pkg::SAMPLE_W-1:0] low_ff, low_in;
   logic                             neg_ff, neg_in;

   logic [pcmfade_pkg::PROD_W-1:0]   acc_sum;
   logic [pcmfade_pkg::NUM_W:0]      trial;
   logic                             qbit;

   assign acc_sum = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
   assign trial   = {rem_ff, low_ff[pcmfade_pkg::SAMPLE_W-1]};
   assign qbit    = (trial >= {1'b0, den_ff});

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      low_in    = low_ff;
      neg_in    = neg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in  = ST_MUL;
               count_in  = '0;
               acc_in    = '0;
               mcand_in  = pcmfade_pkg::PROD_W'(job.mag);
               mplier_in = job.num;
               den_in    = job.den;
               neg_in    = job.neg;
            end
         end
         ST_MUL: begin
            acc_in    = acc_sum;
            mcand_in  = {mcand_ff[pcmfade_pkg::PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[pcmfade_pkg::NUM_W-1:1]};
            count_in  = count_ff + 1'b1;
            if (count_ff == pcmfade_pkg::CNT_W'(pcmfade_pkg::MUL_CYCLES - 1)) begin
               // quotient fits the sample width, so the top part is below den
               state_in = ST_DIV;
               count_in = '0;
               rem_in   = acc_sum[pcmfade_pkg::PROD_W-1:pcmfade_pkg::SAMPLE_W];
               low_in   = acc_sum[pcmfade_pkg::SAMPLE_W-1:0];
            end
         end
         ST_DIV: begin
            rem_in   = qbit ? pcmfade_pkg::NUM_W'(trial - {1'b0, den_ff})
                            : pcmfade_pkg::NUM_W'(trial);
            low_in   = {low_ff[pcmfade_pkg::SAMPLE_W-2:0], qbit};
            count_in = count_ff + 1'b1;
            if (count_ff == pcmfade_pkg::CNT_W'(pcmfade_pkg::DIV_CYCLES - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff  <= count_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      low_ff    <= low_in;
      neg_ff    <= neg_in;
   end

   assign stat.idle = (state_ff == ST_IDLE);
   assign stat.done = (state_ff == ST_DONE);
   assign result    = neg_ff ? -$signed(low_ff) : $signed(low_ff);

endmodule

/* rtl/core/pcm_fade_in_out_ramp.sv */
// ----------------------------------------------------------------------------
// pcm_fade_in_out_ramp
// Linear fade-in / fade-out over a number of buffers for interleaved 16-bit
// PCM, exact rational gain with truncation toward zero.
// ----------------------------------------------------------------------------
//  channel | direction | ports                              | moves
//  req     | in        | req_valid, req_stall, req_data     | sample or command
//  rsp     | out       | rsp_valid, rsp_stall, rsp_data     | scaled sample
//  csr     | in        | csr_write_en, csr_index, csr_wdata | register write
//
//  a command gives no result
//  a sample passes through the bit-serial multiplier and divider before its
//  result reaches the output register
//  req_stall is high while the scaler holds a sample; a result waiting in
//  the output register does not block the next item
//  reset (synchronous) restores registers and fade state, no clearing pass
// ----------------------------------------------------------------------------
module pcm_fade_in_out_ramp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pcmfade_pkg::req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pcmfade_pkg::rsp_type                rsp_data,
   input  logic                                csr_write_en,
   input  logic [pcmfade_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pcmfade_pkg::CSR_W-1:0]       csr_wdata
);

   logic [pcmfade_pkg::CFG_FRM_W-1:0] frames_ff;
   logic [pcmfade_pkg::CFG_CH_W-1:0]  channels_ff;

   logic [1:0]                        fade_mode_ff, fade_mode_in;
   logic [1:0]                        active_ff, active_in;
   logic [pcmfade_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [pcmfade_pkg::FIDX_W-1:0]    frame_ff, frame_in;
   logic [pcmfade_pkg::CH_W-1:0]      chan_ff, chan_in;

   logic                              last_ff, last_in;
   logic [1:0]                        state_out_ff;
   logic                              rsp_valid_ff;
   pcmfade_pkg::rsp_type              rsp_data_ff;

   logic [pcmfade_pkg::FRM_W-1:0]     f_eff;
   logic [pcmfade_pkg::CFG_CH_W-1:0]  c_eff;
   logic [pcmfade_pkg::FRM_W-1:0]     n_sat;
   logic [pcmfade_pkg::FRM_W-1:0]     frame_ext;
   logic [pcmfade_pkg::STEP_W+pcmfade_pkg::FRM_W-1:0] base;
   logic [pcmfade_pkg::STEP_W+pcmfade_pkg::FRM_W-1:0] den_wide;

   logic                              accept;
   logic                              sample_go;
   logic                              transfer;
   pcmfade_pkg::job_type              job;
   pcmfade_pkg::stat_type             stat;
   logic signed [pcmfade_pkg::SAMPLE_W-1:0] scaled;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff   <= pcmfade_pkg::CFG_FRM_W'(1024);
         channels_ff <= pcmfade_pkg::CFG_CH_W'(2);
      end else if (csr_write_en) begin
         unique case (csr_index)
            pcmfade_pkg::REG_FRAMES: begin
               frames_ff <= csr_wdata[pcmfade_pkg::CFG_FRM_W-1:0];
            end
            pcmfade_pkg::REG_CHANNELS: begin
               channels_ff <= csr_wdata[pcmfade_pkg::CFG_CH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // saturated buffer geometry
   always_comb begin
      if (frames_ff == '0) begin
         f_eff = pcmfade_pkg::FRM_W'(1);
      end else if (frames_ff > pcmfade_pkg::MAX_FRAMES) begin
         f_eff = pcmfade_pkg::FRM_W'(pcmfade_pkg::MAX_FRAMES);
      end else begin
         f_eff = pcmfade_pkg::FRM_W'(frames_ff);
      end
      if (channels_ff == '0) begin
         c_eff = pcmfade_pkg::CFG_CH_W'(1);
      end else if (channels_ff > pcmfade_pkg::MAX_CHANNELS) begin
         c_eff = pcmfade_pkg::CFG_CH_W'(pcmfade_pkg::MAX_CHANNELS);
      end else begin
         c_eff = channels_ff;
      end
   end

   assign frame_ext = pcmfade_pkg::FRM_W'(frame_ff);
   assign n_sat     = (frame_ext > f_eff - 1'b1) ? f_eff - 1'b1 : frame_ext;
   // step used in the gain is the one held before this sample
   assign base      = (pcmfade_pkg::STEP_W+pcmfade_pkg::FRM_W)'(step_ff) *
                      (pcmfade_pkg::STEP_W+pcmfade_pkg::FRM_W)'(f_eff);
   assign den_wide  = (pcmfade_pkg::STEP_W+pcmfade_pkg::FRM_W)'(pcmfade_pkg::FADE_STEPS) *
                      (pcmfade_pkg::STEP_W+pcmfade_pkg::FRM_W)'(f_eff);

   assign req_stall = !stat.idle;
   assign accept    = req_valid && !req_stall;
   assign sample_go = accept && (req_data.kind == pcmfade_pkg::KIND_SAMPLE);
   assign transfer  = stat.done && (!rsp_valid_ff || !rsp_stall);

   // fade state, position counters and the job for the scaler
   always_comb begin
      logic [1:0] cur_active;
      logic       frame_wrap;

      fade_mode_in = fade_mode_ff;
      active_in    = active_ff;
      step_in      = step_ff;
      frame_in     = frame_ff;
      chan_in      = chan_ff;
      last_in      = last_ff;
      cur_active   = active_ff;
      frame_wrap   = 1'b0;

      job.mag = req_data.sample_in[pcmfade_pkg::SAMPLE_W-1]
              ? pcmfade_pkg::SAMPLE_W'(-req_data.sample_in)
              : pcmfade_pkg::SAMPLE_W'(req_data.sample_in);
      job.neg = req_data.sample_in[pcmfade_pkg::SAMPLE_W-1];
      job.den = pcmfade_pkg::NUM_W'(den_wide);
      job.num = pcmfade_pkg::NUM_W'(den_wide);

      if (frame_ff == '0 && chan_ff == '0) begin
         if (fade_mode_ff == pcmfade_pkg::MODE_OUT && step_ff != '0) begin
            cur_active = pcmfade_pkg::MODE_OUT;
         end else if (fade_mode_ff == pcmfade_pkg::MODE_IN &&
                      step_ff != pcmfade_pkg::STEP_W'(pcmfade_pkg::FADE_STEPS)) begin
            cur_active = pcmfade_pkg::MODE_IN;
         end else begin
            cur_active = pcmfade_pkg::MODE_NONE;
         end
      end

      if (cur_active == pcmfade_pkg::MODE_OUT) begin
         job.num = pcmfade_pkg::NUM_W'(base - n_sat);
      end else if (cur_active == pcmfade_pkg::MODE_IN) begin
         job.num = pcmfade_pkg::NUM_W'(base + n_sat + 1'b1);
      end

      if (accept) begin
         case (req_data.kind)
            pcmfade_pkg::KIND_FADE_OUT: begin
               if (fade_mode_ff == pcmfade_pkg::MODE_NONE) begin
                  step_in = pcmfade_pkg::STEP_W'(pcmfade_pkg::FADE_STEPS);
               end
               fade_mode_in = pcmfade_pkg::MODE_OUT;
            end
            pcmfade_pkg::KIND_FADE_IN: begin
               if (fade_mode_ff == pcmfade_pkg::MODE_NONE) begin
                  step_in = '0;
               end
               fade_mode_in = pcmfade_pkg::MODE_IN;
            end
            pcmfade_pkg::KIND_CANCEL: begin
               fade_mode_in = pcmfade_pkg::MODE_NONE;
               active_in    = pcmfade_pkg::MODE_NONE;
               step_in      = pcmfade_pkg::STEP_W'(pcmfade_pkg::FADE_STEPS);
            end
            default: begin
               active_in = cur_active;
               if (pcmfade_pkg::CFG_CH_W'(chan_ff) + 1'b1 >= c_eff) begin
                  chan_in = '0;
                  if (frame_ext + 1'b1 >= f_eff) begin
                     frame_in   = '0;
                     frame_wrap = 1'b1;
                  end else begin
                     frame_in = frame_ff + 1'b1;
                  end
               end else begin
                  chan_in = chan_ff + 1'b1;
               end
               last_in = frame_wrap;
               if (frame_wrap) begin
                  if (cur_active == pcmfade_pkg::MODE_OUT && step_ff != '0) begin
                     step_in = step_ff - 1'b1;
                  end else if (cur_active == pcmfade_pkg::MODE_IN &&
                               step_ff != pcmfade_pkg::STEP_W'(pcmfade_pkg::FADE_STEPS)) begin
                     step_in = step_ff + 1'b1;
                  end
                  if (fade_mode_ff == pcmfade_pkg::MODE_OUT && step_in == '0) begin
                     fade_mode_in = pcmfade_pkg::MODE_NONE;
                  end else if (fade_mode_ff == pcmfade_pkg::MODE_IN &&
                               step_in == pcmfade_pkg::STEP_W'(pcmfade_pkg::FADE_STEPS)) begin
                     fade_mode_in = pcmfade_pkg::MODE_NONE;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_mode_ff <= pcmfade_pkg::MODE_NONE;
         active_ff    <= pcmfade_pkg::MODE_NONE;
         step_ff      <= pcmfade_pkg::STEP_W'(pcmfade_pkg::FADE_STEPS);
         frame_ff     <= '0;
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fade_mode_ff <= fade_mode_in;
         active_ff    <= active_in;
         step_ff      <= step_in;
         frame_ff     <= frame_in;
         chan_ff      <= chan_in;
         if (transfer) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      last_ff <= last_in;
      if (sample_go) begin
         state_out_ff <= fade_mode_in;
      end
      if (transfer) begin
         rsp_data_ff.sample_out  <= scaled;
         rsp_data_ff.buffer_last <= last_ff;
         rsp_data_ff.fade_state  <= state_out_ff;
      end
   end

   pcmfade_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (sample_go),
      .job    (job),
      .take   (transfer),
      .stat   (stat),
      .result (scaled)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* bench/pcm_fade_in_out_ramp_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm_fade_in_out_ramp_tb
// Sends samples and fade commands into the fade ramp. A local copy of the fade
// state predicts each scaled sample, and the scaled samples are checked in
// order. The run covers several buffer and channel sizes and random handshake
// idling on both sides.
// ----------------------------------------------------------------------------
module pcm_fade_in_out_ramp_tb;

   localparam int RANDOM_ITEMS  = 1950;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 40;

   logic                              clock        = 1'b0;
   logic                              reset        = 1'b1;
   logic                              req_valid    = 1'b0;
   logic                              req_stall;
   pcmfade_pkg::req_type              req_data     = '0;
   logic                              rsp_valid;
   logic                              rsp_stall    = 1'b0;
   pcmfade_pkg::rsp_type              rsp_data;
   logic                              csr_write_en = 1'b0;
   logic [pcmfade_pkg::CSR_IDX_W-1:0] csr_index    = pcmfade_pkg::REG_FRAMES;
   logic [pcmfade_pkg::CSR_W-1:0]     csr_wdata    = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int errors        = 0;

   // local copy of the registers and the fade state
   logic [pcmfade_pkg::CFG_FRM_W-1:0] frames_reg   = 13'd1024;
   logic [pcmfade_pkg::CFG_CH_W-1:0]  chans_reg    = 4'd2;
   logic [1:0]                        cur_mode     = pcmfade_pkg::MODE_NONE;
   logic [1:0]                        latched_mode = pcmfade_pkg::MODE_NONE;
   int unsigned                       step_cnt     = pcmfade_pkg::FADE_STEPS;
   int unsigned                       frame_pos    = 0;
   int unsigned                       chan_pos     = 0;

   pcmfade_pkg::rsp_type scaled_q[$];

   pcm_fade_in_out_ramp u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // updates the fade state for one item and queues the scaled sample it yields
   task automatic ramp_apply(input pcmfade_pkg::req_type item);
      int unsigned          f, c, n;
      longint               s, num, den, r;
      logic                 last;
      pcmfade_pkg::rsp_type res;
      case (item.kind)
         pcmfade_pkg::KIND_FADE_OUT: begin
            if (cur_mode == pcmfade_pkg::MODE_NONE) step_cnt = pcmfade_pkg::FADE_STEPS;
            cur_mode = pcmfade_pkg::MODE_OUT;
         end
         pcmfade_pkg::KIND_FADE_IN: begin
            if (cur_mode == pcmfade_pkg::MODE_NONE) step_cnt = 0;
            cur_mode = pcmfade_pkg::MODE_IN;
         end
         pcmfade_pkg::KIND_CANCEL: begin
            cur_mode     = pcmfade_pkg::MODE_NONE;
            latched_mode = pcmfade_pkg::MODE_NONE;
            step_cnt     = pcmfade_pkg::FADE_STEPS;
         end
         default: begin
            f = (frames_reg == 0) ? 1 :
                (frames_reg > pcmfade_pkg::MAX_FRAMES) ? pcmfade_pkg::MAX_FRAMES : frames_reg;
            c = (chans_reg == 0) ? 1 :
                (chans_reg > pcmfade_pkg::MAX_CHANNELS) ? pcmfade_pkg::MAX_CHANNELS : chans_reg;
            if (frame_pos == 0 && chan_pos == 0) begin
               // a fade with no steps left latches as none
               if (cur_mode == pcmfade_pkg::MODE_OUT && step_cnt > 0)
                  latched_mode = pcmfade_pkg::MODE_OUT;
               else if (cur_mode == pcmfade_pkg::MODE_IN && step_cnt < pcmfade_pkg::FADE_STEPS)
                  latched_mode = pcmfade_pkg::MODE_IN;
               else
                  latched_mode = pcmfade_pkg::MODE_NONE;
            end
            s   = longint'($signed(item.sample_in));
            n   = (frame_pos > f - 1) ? f - 1 : frame_pos;
            den = longint'(pcmfade_pkg::FADE_STEPS) * longint'(f);
            r   = s;
            if (latched_mode == pcmfade_pkg::MODE_OUT) begin
               num = longint'(step_cnt) * longint'(f) - longint'(n);
               r   = (s * num) / den;
            end else if (latched_mode == pcmfade_pkg::MODE_IN) begin
               num = longint'(step_cnt) * longint'(f) + longint'(n) + 1;
               r   = (s * num) / den;
            end
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            // at-or-beyond compares so a shrunk buffer ends at once
            last = 1'b0;
            if (chan_pos + 1 >= c) begin
               chan_pos = 0;
               if (frame_pos + 1 >= f) begin
                  frame_pos = 0;
                  last      = 1'b1;
               end else begin
                  frame_pos++;
               end
            end else begin
               chan_pos++;
            end
            if (last) begin
               if (latched_mode == pcmfade_pkg::MODE_OUT && step_cnt > 0)
                  step_cnt--;
               else if (latched_mode == pcmfade_pkg::MODE_IN &&
                        step_cnt < pcmfade_pkg::FADE_STEPS)
                  step_cnt++;
               if (cur_mode == pcmfade_pkg::MODE_OUT && step_cnt == 0)
                  cur_mode = pcmfade_pkg::MODE_NONE;
               else if (cur_mode == pcmfade_pkg::MODE_IN &&
                        step_cnt == pcmfade_pkg::FADE_STEPS)
                  cur_mode = pcmfade_pkg::MODE_NONE;
            end
            res.sample_out  = r[pcmfade_pkg::SAMPLE_W-1:0];
            res.buffer_last = last;
            res.fade_state  = cur_mode;
            scaled_q.push_back(res);
         end
      endcase
   endtask

   always @(posedge clock) begin
      pcmfade_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (scaled_q.size() == 0) begin
            $error("result with nothing expected: sample_out %0d", rsp_data.sample_out);
            errors++;
         end else begin
            want = scaled_q.pop_front();
            if (rsp_data.sample_out !== want.sample_out) begin
               $error("sample_out: expected %0d, got %0d", want.sample_out, rsp_data.sample_out);
               errors++;
            end
            if (rsp_data.buffer_last !== want.buffer_last) begin
               $error("buffer_last: expected %0d, got %0d",
                      want.buffer_last, rsp_data.buffer_last);
               errors++;
            end
            if (rsp_data.fade_state !== want.fade_state) begin
               $error("fade_state: expected %0d, got %0d", want.fade_state, rsp_data.fade_state);
               errors++;
            end
         end
      end
   end

   // valid stays high after an accepted item; a drain, or idling in the next send, lowers it
   task automatic send_item(input logic [1:0] kind,
                            input logic signed [pcmfade_pkg::SAMPLE_W-1:0] value);
      pcmfade_pkg::req_type item;
      item.kind      = kind;
      item.sample_in = value;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      ramp_apply(item);
   endtask

   task automatic drain_results();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (scaled_q.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (scaled_q.size() != 0) begin
         $error("%0d expected results never arrived", scaled_q.size());
         errors++;
         scaled_q.delete();
      end
      // commands give no result, let the block go quiet
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [pcmfade_pkg::CSR_W-1:0] frames,
                             input logic [pcmfade_pkg::CSR_W-1:0] chans);
      csr_write_en <= 1'b1;
      csr_index    <= pcmfade_pkg::REG_FRAMES;
      csr_wdata    <= frames;
      @(posedge clock);
      frames_reg = frames[pcmfade_pkg::CFG_FRM_W-1:0];
      csr_index <= pcmfade_pkg::REG_CHANNELS;
      csr_wdata <= chans;
      @(posedge clock);
      chans_reg = chans[pcmfade_pkg::CFG_CH_W-1:0];
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [pcmfade_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(11))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         4:       return 16'sh0001;
         default: return pcmfade_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   // registers at their reset sizes, a fade requested in mid-buffer does not latch
   task automatic test_default_registers();
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'sh7FFF);
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'sh8000);
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'sh0000);
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'shFFFF);
      send_item(pcmfade_pkg::KIND_FADE_OUT, 16'sh1234);
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'sd5);
      send_item(pcmfade_pkg::KIND_SAMPLE, -16'sd5);
      send_item(pcmfade_pkg::KIND_CANCEL, 16'shFFFF);
      drain_results();
   endtask

   // one-sample buffers: each sample closes a buffer and so steps any active fade
   task automatic test_fade_corners();
      write_regs(13'd1, 13'd1);
      // position is past the new end, so this buffer closes at once
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'sd100);
      // fade-out requested while a fade-in sits at step zero
      send_item(pcmfade_pkg::KIND_FADE_IN, 16'sh0000);
      send_item(pcmfade_pkg::KIND_FADE_OUT, 16'sh0000);
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'sh7FFF);
      // fade-in requested while a fade-out sits at full level
      send_item(pcmfade_pkg::KIND_FADE_OUT, 16'sh0000);
      send_item(pcmfade_pkg::KIND_FADE_IN, 16'sh0000);
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'sh8000);
      send_item(pcmfade_pkg::KIND_FADE_OUT, 16'sh5555);
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'sh7FFF);
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'sh8000);
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'shFFFF);
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'sh0001);
      // reverse direction keeps the step
      send_item(pcmfade_pkg::KIND_FADE_IN, 16'shAAAA);
      send_item(pcmfade_pkg::KIND_SAMPLE, -16'sd12345);
      send_item(pcmfade_pkg::KIND_CANCEL, 16'sh0000);
      send_item(pcmfade_pkg::KIND_SAMPLE, 16'sh7FFF);
      drain_results();
   endtask

   task automatic test_random_traffic();
      int                            ph, len, pause_at, i, sel;
      int unsigned                   sent;
      logic                          big;
      logic [1:0]                    kind;
      logic [pcmfade_pkg::CSR_W-1:0] frames, chans;
      sent = 0;
      ph   = 0;
      while (sent < RANDOM_ITEMS) begin
         drain_results();
         case (ph % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 66; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 6;  stall_pct = 6;  end
         endcase
         big = 1'b0;
         if (ph < 4) begin
            big = 1'b1;
            case (ph)
               0: begin
                  frames = pcmfade_pkg::CSR_W'(pcmfade_pkg::MAX_FRAMES);
                  chans  = pcmfade_pkg::CSR_W'(pcmfade_pkg::MAX_CHANNELS);
               end
               1: begin
                  frames = 13'h1FFF;
                  chans  = 13'd15;
               end
               2: begin
                  frames = 13'd0;
                  chans  = 13'd0;
               end
               default: begin
                  frames = pcmfade_pkg::CSR_W'(pcmfade_pkg::MAX_FRAMES - 1);
                  chans  = 13'd1;
               end
            endcase
         end else begin
            sel = $urandom_range(9);
            if (sel == 0) begin
               big    = 1'b1;
               frames = pcmfade_pkg::CSR_W'($urandom_range(1, 8191));
               chans  = pcmfade_pkg::CSR_W'($urandom_range(0, 15));
            end else if (sel < 3) begin
               frames = pcmfade_pkg::CSR_W'($urandom_range(1, 16));
               chans  = pcmfade_pkg::CSR_W'($urandom_range(1, pcmfade_pkg::MAX_CHANNELS));
            end else begin
               frames = pcmfade_pkg::CSR_W'($urandom_range(1, 3));
               chans  = pcmfade_pkg::CSR_W'($urandom_range(1, 3));
            end
         end
         // close the open buffer so large buffers start from frame zero
         if (big || $urandom_range(3) == 0) begin
            write_regs(13'd1, 13'd1);
            send_item(pcmfade_pkg::KIND_SAMPLE, pick_sample());
            drain_results();
            sent++;
         end
         write_regs(frames, chans);
         len      = big ? 40 : $urandom_range(60, 140);
         pause_at = $urandom_range(1, len - 1);
         for (i = 0; i < len; i++) begin
            // sender holds until every result is back
            if (i == pause_at) drain_results();
            sel = $urandom_range(99);
            if (big && i == 0)
               kind = (sel < 50) ? pcmfade_pkg::KIND_FADE_OUT : pcmfade_pkg::KIND_FADE_IN;
            else if (sel < 93)
               kind = pcmfade_pkg::KIND_SAMPLE;
            else if (sel < 96)
               kind = pcmfade_pkg::KIND_FADE_OUT;
            else if (sel < 99)
               kind = pcmfade_pkg::KIND_FADE_IN;
            else
               kind = pcmfade_pkg::KIND_CANCEL;
            send_item(kind, pick_sample());
         end
         sent += len;
         ph++;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_registers();
      test_fade_corners();
      test_random_traffic();
      drain_results();
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

/* pcm_fade_in_out_ramp.f */
rtl/core/pcmfade_pkg.sv
rtl/core/pcmfade_scale.sv
rtl/core/pcm_fade_in_out_ramp.sv
bench/pcm_fade_in_out_ramp_tb.sv
